// File: rtl/qmu_pkg.sv
// ============================================================================
// qmu_pkg
// Types, widths and the rounding/saturation helper for the quaternion
// multiply unit.
// ============================================================================
`default_nettype none

package qmu_pkg;

  // Fixed-point format: signed Q1.14 components.
  localparam int FRAC_BITS = 14;
  localparam int COMP_W    = 16;
  localparam int PROD_W    = 2 * COMP_W;          // one component product
  localparam int PAIR_W    = PROD_W + 1;          // sum of two products
  localparam int SUM_W     = PROD_W + 2;          // sum of four products
  localparam int QUO_W     = SUM_W - FRAC_BITS;   // value after the shift

  localparam int NUM_PROD  = 16;
  localparam int NUM_PAIR  = 8;
  localparam int NUM_COMP  = 4;

  // Half an output LSB, added before the floor shift.
  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (FRAC_BITS - 1);

  localparam logic signed [QUO_W-1:0] SAT_MAX = QUO_W'((1 <<< (COMP_W - 1)) - 1);
  localparam logic signed [QUO_W-1:0] SAT_MIN = -QUO_W'(1 <<< (COMP_W - 1));

  typedef logic signed [COMP_W-1:0] comp_t;

  typedef struct packed {
    comp_t w;
    comp_t z;
    comp_t y;
    comp_t x;
  } quat_t;

  typedef struct packed {
    comp_t val;
    logic  clamp;
  } sat_res_t;

  // Floor shift of an already rounded sum, then clamp to the 16-bit range.
  function automatic sat_res_t round_sat(input logic signed [SUM_W-1:0] t);
    logic signed [QUO_W-1:0] q;
    sat_res_t                r;
    q = QUO_W'(t >>> FRAC_BITS);
    if (q > SAT_MAX) begin
      r.val   = COMP_W'(SAT_MAX);
      r.clamp = 1'b1;
    end else if (q < SAT_MIN) begin
      r.val   = COMP_W'(SAT_MIN);
      r.clamp = 1'b1;
    end else begin
      r.val   = COMP_W'(q);
      r.clamp = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/quaternion_multiply_unit.sv
// ============================================================================
// quaternion_multiply_unit
// Streaming Hamilton product of two Q1.14 quaternions (second * first).
// ============================================================================
// Each input item carries two quaternions and yields one product item, which
// is presented on the output from the last stage register. The datapath is a
// four-stage pipeline: sixteen 16x16 component products, pairwise sums, the
// four-term sums with the rounding half added, and finally the floor shift and
// clamp to 16 bits. A new item is accepted every cycle while the output is
// taken; when the output stalls, the stages fill up and the input holds off
// only once all four are occupied. Each component is rounded to nearest with
// ties toward positive infinity, and the saturated flag is set when any
// component was clamped.
`default_nettype none

module quaternion_multiply_unit
  import qmu_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,

  input  wire logic         s_tvalid,
  output logic              s_tready,
  // first_x, first_y, first_z, first_w, second_x, second_y, second_z, second_w
  input  wire logic [127:0] s_tdata,

  output logic              m_tvalid,
  input  wire logic         m_tready,
  // out_x, out_y, out_z, out_w
  output logic [63:0]       m_tdata,
  // saturated
  output logic [7:0]        m_tuser
);

  // Stage valid bits and the stall chain.
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4     = !v4 || m_tready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;

  // Input unpacking.
  quat_t q1, q2;
  assign q1 = quat_t'(s_tdata[63:0]);
  assign q2 = quat_t'(s_tdata[127:64]);

  // Stage 1: component products.
  logic signed [PROD_W-1:0] prod      [NUM_PROD];
  logic signed [PROD_W-1:0] prod_next [NUM_PROD];

  always_comb begin
    // x terms
    prod_next[0]  = q2.w * q1.x;
    prod_next[1]  = q1.w * q2.x;
    prod_next[2]  = q2.y * q1.z;
    prod_next[3]  = q2.z * q1.y;
    // y terms
    prod_next[4]  = q2.w * q1.y;
    prod_next[5]  = q1.w * q2.y;
    prod_next[6]  = q2.z * q1.x;
    prod_next[7]  = q2.x * q1.z;
    // z terms
    prod_next[8]  = q2.w * q1.z;
    prod_next[9]  = q1.w * q2.z;
    prod_next[10] = q2.x * q1.y;
    prod_next[11] = q2.y * q1.x;
    // w terms
    prod_next[12] = q1.w * q2.w;
    prod_next[13] = q1.x * q2.x;
    prod_next[14] = q1.y * q2.y;
    prod_next[15] = q1.z * q2.z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && s_tvalid) begin
      prod <= prod_next;
    end
  end

  // Stage 2: pairwise sums, with the cross-product and dot-product signs.
  logic signed [PAIR_W-1:0] pair      [NUM_PAIR];
  logic signed [PAIR_W-1:0] pair_next [NUM_PAIR];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      pair_next[2*c]   = PAIR_W'(prod[4*c])   + PAIR_W'(prod[4*c+1]);
      pair_next[2*c+1] = PAIR_W'(prod[4*c+2]) - PAIR_W'(prod[4*c+3]);
    end
    pair_next[6] = PAIR_W'(prod[12]) - PAIR_W'(prod[13]);
    pair_next[7] = -PAIR_W'(prod[14]) - PAIR_W'(prod[15]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      pair <= pair_next;
    end
  end

  // Stage 3: four-term sums plus half an LSB for rounding.
  logic signed [SUM_W-1:0] sum      [NUM_COMP];
  logic signed [SUM_W-1:0] sum_next [NUM_COMP];

  always_comb begin
    for (int c = 0; c < NUM_COMP; c++) begin
      sum_next[c] = SUM_W'(pair[2*c]) + SUM_W'(pair[2*c+1]) + ROUND_HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      sum <= sum_next;
    end
  end

  // Stage 4: floor shift and clamp; this is the output register.
  sat_res_t res [NUM_COMP];
  quat_t    out_q;
  logic     out_sat;

  always_comb begin
    for (int c = 0; c < NUM_COMP; c++) begin
      res[c] = round_sat(sum[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (rdy4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      out_q.x <= res[0].val;
      out_q.y <= res[1].val;
      out_q.z <= res[2].val;
      out_q.w <= res[3].val;
      out_sat <= res[0].clamp | res[1].clamp | res[2].clamp | res[3].clamp;
    end
  end

  assign m_tvalid = v4;
  assign m_tdata  = out_q;
  assign m_tuser  = {7'b0, out_sat};

  // The flag is only raised when some component sits at a clamp limit.
  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_sat |->
      (out_q.x == COMP_W'(SAT_MAX)) || (out_q.x == COMP_W'(SAT_MIN)) ||
      (out_q.y == COMP_W'(SAT_MAX)) || (out_q.y == COMP_W'(SAT_MIN)) ||
      (out_q.z == COMP_W'(SAT_MAX)) || (out_q.z == COMP_W'(SAT_MIN)) ||
      (out_q.w == COMP_W'(SAT_MAX)) || (out_q.w == COMP_W'(SAT_MIN)))
    else $error("saturated flag set with no clamped component");

  // The input is held off only when every stage holds an item.
  a_full_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> v1 && v2 && v3 && v4 && !m_tready)
    else $error("input stalled while the pipeline has room");

  // An accepted item always lands in the first stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> v1)
    else $error("accepted item lost at the first stage");

  // A stalled output item keeps the stage behind it occupied.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    v4 && !m_tready && v3 |=> v4 && v3)
    else $error("item dropped from a stalled pipeline");

endmodule

`default_nettype wire

// File: dv/quaternion_multiply_unit_test.sv
// ----------------------------------------------------------------------------
// Quaternion multiply unit testbench
// Feeds quaternion pairs through the input stream and checks every product
// item against a Hamilton product computed here in exact 64-bit arithmetic.
// The products are rounded to nearest and clamped to 16 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quaternion_multiply_unit_test
  import qmu_pkg::*;
();

  localparam int RANDOM_PAIRS   = 1550;
  localparam int MAX_WAIT       = 6;
  localparam int HOLD_CYCLES    = 80;
  localparam int HOLD_SPACING   = 400;
  localparam int HOLD_COUNT     = 2;
  localparam int DRAIN_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 2000;

  // One input item: the first quaternion sits in the low 64 bits.
  typedef struct packed {
    quat_t second;
    quat_t first;
  } quat_pair_t;

  typedef struct {
    quat_t prod;
    logic  sat;
  } product_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [63:0]  m_tdata;
  logic [7:0]   m_tuser;

  quat_pair_t pending_pairs[$];
  product_t   expected_products[$];

  int error_count   = 0;
  int results_seen  = 0;
  int send_gap      = 0;
  int recv_gap      = 0;
  int hold_left     = 0;
  int holds_fired   = 0;
  int idle_cycles   = 0;
  bit send_no_idle  = 1'b0;
  bit recv_no_idle  = 1'b0;

  quaternion_multiply_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // Exact product second * first, rounded with ties upward and clamped.
  function automatic product_t hamilton_product(quat_pair_t p);
    longint   x1, y1, z1, w1, x2, y2, z2, w2;
    longint   sums[4];
    longint   q;
    comp_t    comps[4];
    product_t r;
    x1 = p.first.x;  y1 = p.first.y;  z1 = p.first.z;  w1 = p.first.w;
    x2 = p.second.x; y2 = p.second.y; z2 = p.second.z; w2 = p.second.w;
    sums[0] = w2 * x1 + w1 * x2 + (y2 * z1 - z2 * y1);
    sums[1] = w2 * y1 + w1 * y2 + (z2 * x1 - x2 * z1);
    sums[2] = w2 * z1 + w1 * z2 + (x2 * y1 - y2 * x1);
    sums[3] = w1 * w2 - (x1 * x2 + y1 * y2 + z1 * z2);
    r.sat = 1'b0;
    for (int i = 0; i < 4; i++) begin
      // Arithmetic shift of a signed longint is a floor division.
      q = (sums[i] + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (q > 32767) begin
        q = 32767;
        r.sat = 1'b1;
      end else if (q < -32768) begin
        q = -32768;
        r.sat = 1'b1;
      end
      comps[i] = comp_t'(q);
    end
    r.prod.x = comps[0];
    r.prod.y = comps[1];
    r.prod.z = comps[2];
    r.prod.w = comps[3];
    return r;
  endfunction

  // Component drawn in one of three ranges: near unit, any pattern, or extremes.
  function automatic comp_t random_comp(int style);
    int pick;
    case (style)
      0: begin
        return comp_t'($urandom_range(0, 32768) - 16384);
      end
      1: begin
        return comp_t'($urandom);
      end
      default: begin
        pick = $urandom_range(0, 7);
        case (pick)
          0: return comp_t'(-32768);
          1: return comp_t'(-32767);
          2: return comp_t'(-1);
          3: return comp_t'(0);
          4: return comp_t'(1);
          5: return comp_t'(16384);
          6: return comp_t'(32767);
          default: return comp_t'($urandom);
        endcase
      end
    endcase
  endfunction

  task automatic add_pair(int fx, int fy, int fz, int fw, int sx, int sy, int sz, int sw);
    quat_pair_t p;
    p.first.x  = comp_t'(fx);
    p.first.y  = comp_t'(fy);
    p.first.z  = comp_t'(fz);
    p.first.w  = comp_t'(fw);
    p.second.x = comp_t'(sx);
    p.second.y = comp_t'(sy);
    p.second.z = comp_t'(sz);
    p.second.w = comp_t'(sw);
    pending_pairs.push_back(p);
  endtask

  // Input driver: offers queued items, holding each until it is taken.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_products.push_back(hamilton_product(quat_pair_t'(s_tdata)));
      end
      if (s_tvalid && !s_tready) begin
        // Keep offering the same item.
      end else if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        s_tvalid <= 1'b0;
      end else if (pending_pairs.size() != 0) begin
        s_tdata  <= pending_pairs.pop_front();
        s_tvalid <= 1'b1;
        if ($urandom_range(0, 39) == 0) send_no_idle = !send_no_idle;
        send_gap <= send_no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver stall, counted here so the pipeline fills and backs up.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_fired < HOLD_COUNT &&
                 results_seen >= HOLD_SPACING * (holds_fired + 1)) begin
      hold_left   <= HOLD_CYCLES;
      holds_fired <= holds_fired + 1;
    end
  end

  // Output monitor: checks each taken product item and paces m_tready.
  always @(posedge clk) begin
    product_t exp_prod;
    quat_t    got;
    if (rst) begin
      m_tready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen <= results_seen + 1;
        got = quat_t'(m_tdata);
        if (expected_products.size() == 0) begin
          $error("product item with no expectation waiting: %h", m_tdata);
          error_count++;
        end else begin
          exp_prod = expected_products.pop_front();
          if (got.x !== exp_prod.prod.x) begin
            $error("out_x: expected %0d, actual %0d", exp_prod.prod.x, got.x);
            error_count++;
          end
          if (got.y !== exp_prod.prod.y) begin
            $error("out_y: expected %0d, actual %0d", exp_prod.prod.y, got.y);
            error_count++;
          end
          if (got.z !== exp_prod.prod.z) begin
            $error("out_z: expected %0d, actual %0d", exp_prod.prod.z, got.z);
            error_count++;
          end
          if (got.w !== exp_prod.prod.w) begin
            $error("out_w: expected %0d, actual %0d", exp_prod.prod.w, got.w);
            error_count++;
          end
          if (m_tuser[0] !== exp_prod.sat) begin
            $error("saturated: expected %0d, actual %0d", exp_prod.sat, m_tuser[0]);
            error_count++;
          end
        end
        if ($urandom_range(0, 39) == 0) recv_no_idle = !recv_no_idle;
        recv_gap = recv_no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (hold_left != 0) begin
        m_tready <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap = recv_gap - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles in which neither side moves an item.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int style;
    quat_pair_t p;

    // Directed items: zeros, identities, extremes, ties and each clamp.
    add_pair(0, 0, 0, 0, 0, 0, 0, 0);
    add_pair(0, 0, 0, 16384, 0, 0, 0, 16384);
    add_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    add_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    add_pair(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767);
    add_pair(16384, 0, 0, 0, 16384, 0, 0, 0);
    add_pair(16384, 0, 0, 0, 0, 16384, 0, 0);
    add_pair(0, 16384, 0, 0, 0, 0, 16384, 0);
    // A tie on a positive half rounds up, one on a negative half toward zero.
    add_pair(0, 0, 0, 1, 0, 0, 0, 8192);
    add_pair(0, 0, 0, -1, 0, 0, 0, 8192);
    add_pair(0, 0, 0, -1, 0, 0, 0, 8193);
    add_pair(0, 0, 0, 1, 0, 0, 0, 8191);
    // Clamping high and low on the scalar, and once on each vector component.
    add_pair(0, 0, 0, 32767, 0, 0, 0, 32767);
    add_pair(0, 0, 0, 32767, 0, 0, 0, -32768);
    add_pair(32767, 0, 0, 0, 0, 0, 0, 32767);
    add_pair(0, -32768, 0, 0, 0, 0, 0, 32767);
    add_pair(0, 32767, 0, 0, 32767, 0, 0, 0);
    // Values landing exactly on the range ends, and one just past.
    add_pair(0, 0, 0, -32768, 0, 0, 0, 16384);
    add_pair(0, 0, 0, 32767, 0, 0, 0, 16384);
    add_pair(0, 0, 0, -32768, 0, 0, 0, -16384);
    add_pair(16'h5555, 16'haaaa, 16'h5555, 16'haaaa,
             16'haaaa, 16'h5555, 16'haaaa, 16'h5555);

    // Random items, half near unit length, the rest full patterns and extremes.
    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      style = $urandom_range(0, 9);
      style = (style < 5) ? 0 : (style < 8) ? 1 : 2;
      p.first.x  = random_comp(style);
      p.first.y  = random_comp(style);
      p.first.z  = random_comp(style);
      p.first.w  = random_comp(style);
      p.second.x = random_comp(style);
      p.second.y = random_comp(style);
      p.second.z = random_comp(style);
      p.second.w = random_comp(style);
      pending_pairs.push_back(p);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Sample at the falling edge, once every clocked update has settled.
    do @(negedge clk);
    while (pending_pairs.size() != 0 || s_tvalid || expected_products.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && expected_products.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
